// ===== design/ptf_pkg.sv =====
// ----------------------------------------------------------------------------
// ptf_pkg
// Shared constants, types and gamma tables for the pixel tone filter.
// ----------------------------------------------------------------------------
package ptf_pkg;

  localparam int FracBitsDef = 16;

  localparam logic [1:0] MODE_COLOUR = 2'd0;
  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_GREEN  = 2'd2;
  localparam logic [1:0] MODE_SEPIA  = 2'd3;

  localparam logic [1:0] REG_TONE  = 2'd0;
  localparam logic [1:0] REG_BOOST = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;

  typedef struct packed {
    logic [1:0] tone_mode;
    logic [1:0] boost;
    logic       alpha_present;
  } cfg_t;

  typedef logic [255:0][7:0] lut_t;

  // entry p: largest v <= lim with v == 0 or (2v-1)^5 * k1 <= k2 * p^6
  function automatic lut_t build_lut(input longint k1, input longint k2, input int lim);
    lut_t tbl;
    longint q;
    longint rhs;
    longint t;
    int v;
    logic more;
    v = 0;
    for (int i = 0; i < 256; i++) begin
      q = longint'(i);
      rhs = k2 * q * q * q * q * q * q;
      more = 1'b1;
      while (more) begin
        t = 2 * longint'(v + 1) - 1;
        if (v < lim && t * t * t * t * t * k1 <= rhs) v = v + 1;
        else more = 1'b0;
      end
      tbl[i] = 8'(v);
    end
    return tbl;
  endfunction

  localparam lut_t FullLut = build_lut(64'd255, 64'd32, 255);
  localparam lut_t TintLut = build_lut(64'd796875, 64'd7776, 153);

  function automatic logic [7:0] rom_full(input logic [7:0] p);
    return FullLut[p];
  endfunction

  function automatic logic [7:0] rom_tint(input logic [7:0] p);
    return TintLut[p];
  endfunction

endpackage

// ===== design/ptf_core.sv =====
// ----------------------------------------------------------------------------
// ptf_core
// Four-stage pipeline: sums, mono quotient/select, scaling/lookup, offset/saturate.
// ----------------------------------------------------------------------------
module ptf_core #(
  parameter int FRAC_BITS = ptf_pkg::FracBitsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_v,
  input  ptf_pkg::cfg_t  cfg,
  input  logic [7:0]     c0,
  input  logic [7:0]     c1,
  input  logic [7:0]     c2,
  input  logic [7:0]     alpha_in,
  input  logic           last_in,
  output logic           o_v,
  output logic [7:0]     o0,
  output logic [7:0]     o1,
  output logic [7:0]     o2,
  output logic [7:0]     o3,
  output logic           o_last
);
  import ptf_pkg::*;

  localparam int AW = FRAC_BITS + 12;
  localparam int PW = 2 * FRAC_BITS + 12;
  localparam longint One = longint'(1) << FRAC_BITS;
  localparam longint Den = 100000;
  localparam logic [AW-1:0] K00 = AW'((393 * 85 * One + Den / 2) / Den);
  localparam logic [AW-1:0] K01 = AW'((769 * 85 * One + Den / 2) / Den);
  localparam logic [AW-1:0] K02 = AW'((189 * 85 * One + Den / 2) / Den);
  localparam logic [AW-1:0] K10 = AW'((349 * 85 * One + Den / 2) / Den);
  localparam logic [AW-1:0] K11 = AW'((686 * 85 * One + Den / 2) / Den);
  localparam logic [AW-1:0] K12 = AW'((168 * 85 * One + Den / 2) / Den);
  localparam logic [AW-1:0] K20 = AW'((272 * 85 * One + Den / 2) / Den);
  localparam logic [AW-1:0] K21 = AW'((534 * 85 * One + Den / 2) / Den);
  localparam logic [AW-1:0] K22 = AW'((131 * 85 * One + Den / 2) / Den);
  localparam longint G1F = (150 * One + 50) / 100;
  localparam longint G2F = (225 * One + 50) / 100;
  localparam longint T1F = (90 * One + 50) / 100;
  localparam longint T2F = (135 * One + 50) / 100;
  localparam longint O1F = (2600 * One + 50) / 100;
  localparam longint O2F = (6425 * One + 50) / 100;
  localparam longint SixRecip = ((longint'(1) << 40) + 5) / 6;
  localparam logic [FRAC_BITS-1:0] Sixth1 = FRAC_BITS'((1 * One) / 6);
  localparam logic [FRAC_BITS-1:0] Sixth2 = FRAC_BITS'((2 * One) / 6);
  localparam logic [FRAC_BITS-1:0] Sixth3 = FRAC_BITS'((3 * One) / 6);
  localparam logic [FRAC_BITS-1:0] Sixth4 = FRAC_BITS'((4 * One) / 6);
  localparam logic [FRAC_BITS-1:0] Sixth5 = FRAC_BITS'((5 * One) / 6);

  // stage 1: sums
  logic            v1_r;
  cfg_t            cfg1_r;
  logic [AW-1:0]   a_r [3];
  logic [10:0]     s_r;
  logic [7:0]      p0_r, p1_r, p2_r, al1_r;
  logic            l1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_v;
    if (adv) begin
      cfg1_r <= cfg;
      a_r[0] <= K00 * AW'(c0) + K01 * AW'(c1) + K02 * AW'(c2);
      a_r[1] <= K10 * AW'(c0) + K11 * AW'(c1) + K12 * AW'(c2);
      a_r[2] <= K20 * AW'(c0) + K21 * AW'(c1) + K22 * AW'(c2);
      s_r <= 11'({c0, 1'b0}) + 11'(c1) * 11'd3 + 11'(c2);
      p0_r <= c0; p1_r <= c1; p2_r <= c2;
      al1_r <= cfg.alpha_present ? alpha_in : 8'd0;
      l1_r <= last_in;
    end
  end

  // stage 2: mono quotient and choose value per output, plus lookup index
  logic            v2_r;
  cfg_t            cfg2_r;
  logic [AW-1:0]   x_r [3];
  logic [7:0]      idx_r [3];
  logic [7:0]      al2_r, pp0_r, pp1_r, pp2_r;
  logic            l2_r;
  logic [AW-1:0]   mono_fx;
  logic [7:0]      mono_i;
  logic [51:0]     mprod;
  logic [10:0]     mono_rem;
  logic [FRAC_BITS-1:0] mono_frac;

  function automatic logic [7:0] fidx(input logic [AW-1:0] a);
    logic [AW-FRAC_BITS-1:0] i;
    i = a[AW-1:FRAC_BITS];
    return (i > (AW-FRAC_BITS)'(255)) ? 8'd255 : i[7:0];
  endfunction

  always_comb begin
    mprod = 52'(s_r) * 52'(SixRecip);
    mono_i = mprod[47:40];
    mono_rem = s_r - 11'(mono_i) * 11'd6;
    case (mono_rem[2:0])
      3'd1: mono_frac = Sixth1;
      3'd2: mono_frac = Sixth2;
      3'd3: mono_frac = Sixth3;
      3'd4: mono_frac = Sixth4;
      3'd5: mono_frac = Sixth5;
      default: mono_frac = '0;
    endcase
    mono_fx = AW'({mono_i, mono_frac});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      cfg2_r <= cfg1_r;
      al2_r <= al1_r; l2_r <= l1_r;
      pp0_r <= p2_r; pp1_r <= p1_r; pp2_r <= p0_r;
      case (cfg1_r.tone_mode)
        MODE_COLOUR: begin
          x_r[0] <= AW'(p2_r) << FRAC_BITS;
          x_r[1] <= AW'(p1_r) << FRAC_BITS;
          x_r[2] <= AW'(p0_r) << FRAC_BITS;
          for (int i = 0; i < 3; i++) idx_r[i] <= 8'd0;
        end
        MODE_MONO: begin
          for (int i = 0; i < 3; i++) begin
            x_r[i] <= mono_fx;
            idx_r[i] <= mono_i;
          end
        end
        MODE_GREEN: begin
          x_r[0] <= a_r[2]; x_r[1] <= a_r[0]; x_r[2] <= a_r[1];
          idx_r[0] <= fidx(a_r[2]); idx_r[1] <= fidx(a_r[0]); idx_r[2] <= fidx(a_r[1]);
        end
        default: begin
          x_r[0] <= a_r[2]; x_r[1] <= a_r[1]; x_r[2] <= a_r[0];
          idx_r[0] <= fidx(a_r[2]); idx_r[1] <= fidx(a_r[1]); idx_r[2] <= fidx(a_r[0]);
        end
      endcase
    end
  end

  // stage 3: gain multiply, lookups
  logic            v3_r;
  cfg_t            cfg3_r;
  logic [PW-1:0]   m_r [3];
  logic [7:0]      lk_r [3];
  logic [7:0]      pz_r [3];
  logic [7:0]      al3_r;
  logic            l3_r;
  logic            hi;

  always_comb hi = (cfg2_r.boost != 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      cfg3_r <= cfg2_r; al3_r <= al2_r; l3_r <= l2_r;
      pz_r[0] <= pp0_r; pz_r[1] <= pp1_r; pz_r[2] <= pp2_r;
      for (int i = 0; i < 3; i++) begin
        if (cfg2_r.tone_mode == MODE_GREEN && i != 1)
          m_r[i] <= (PW'(x_r[i]) * PW'(hi ? T2F : T1F)) >> FRAC_BITS;
        else
          m_r[i] <= (PW'(x_r[i]) * PW'(hi ? G2F : G1F)) >> FRAC_BITS;
        lk_r[i] <= (cfg2_r.tone_mode == MODE_GREEN && i != 1) ? rom_tint(idx_r[i])
                                                               : rom_full(idx_r[i]);
      end
    end
  end

  // stage 4: offset, saturate, select
  logic            v4_r;
  logic [7:0]      r_r [3];
  logic [7:0]      al4_r;
  logic            l4_r;
  logic [PW-1:0]   sum [3];
  logic [PW-FRAC_BITS-1:0] ip [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = m_r[i] + PW'(cfg3_r.boost != 2'd1 ? O2F : O1F);
      ip[i] = sum[i][PW-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      al4_r <= al3_r; l4_r <= l3_r;
      for (int i = 0; i < 3; i++) begin
        if (cfg3_r.boost == 2'd0)
          r_r[i] <= (cfg3_r.tone_mode == MODE_COLOUR) ? pz_r[i] : lk_r[i];
        else
          r_r[i] <= (ip[i] > (PW-FRAC_BITS)'(255)) ? 8'd255 : ip[i][7:0];
      end
    end
  end

  assign o_v = v4_r;
  assign o0 = r_r[0];
  assign o1 = r_r[1];
  assign o2 = r_r[2];
  assign o3 = al4_r;
  assign o_last = l4_r;

endmodule

// ===== design/pixel_tone_filter_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_tone_filter_unit
// Colour, mono, green tint and sepia tone filter on a pixel stream.
// ----------------------------------------------------------------------------
// Pipeline: four register stages between the input transfer and the output;
// out_valid is driven from the last stage register.
// Throughput: one pixel per cycle; the four-stage pipeline stalls as one
// when the output is held and its last stage is full.
// Reset: pipeline empties; tone_mode 0, boost_level 0, alpha_present 1.
module pixel_tone_filter_unit #(
  parameter int FRAC_BITS = ptf_pkg::FracBitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_chan0,
  input  logic [7:0] in_chan1,
  input  logic [7:0] in_chan2,
  input  logic [7:0] in_alpha_in,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out0,
  output logic [7:0] out_out1,
  output logic [7:0] out_out2,
  output logic [7:0] out_out3,
  output logic       out_last_out
);
  import ptf_pkg::*;

  cfg_t cfg_r;
  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{tone_mode: MODE_COLOUR, boost: 2'd0, alpha_present: 1'b1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TONE:  cfg_r.tone_mode <= cfg_data;
        REG_BOOST: cfg_r.boost <= cfg_data;
        REG_ALPHA: cfg_r.alpha_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign adv = out_ready || !out_valid;
  assign in_ready = adv;

  ptf_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(in_valid), .cfg(cfg_r),
    .c0(in_chan0), .c1(in_chan1), .c2(in_chan2), .alpha_in(in_alpha_in),
    .last_in(in_last_in), .o_v(out_valid), .o0(out_out0), .o1(out_out1),
    .o2(out_out2), .o3(out_out3), .o_last(out_last_out)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out0) && $stable(out_last_out))
    else $error("output changed while held");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("pipeline stalled while empty");

endmodule

// ===== tb/tb_pixel_tone_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_tone_filter_unit
// Drives pixels through the tone filter under every tone mode, boost level
// and alpha setting, with random gaps and back-pressure, and checks each
// output transfer against a fixed-point tone predictor.
// ----------------------------------------------------------------------------
module tb_pixel_tone_filter_unit;
  import ptf_pkg::*;

  localparam int FB = FracBitsDef;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [7:0] o0;
    logic [7:0] o1;
    logic [7:0] o2;
    logic [7:0] o3;
    logic       last;
  } tone_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_TONE;
  logic [1:0] cfg_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_chan0 = 8'd0;
  logic [7:0] in_chan1 = 8'd0;
  logic [7:0] in_chan2 = 8'd0;
  logic [7:0] in_alpha_in = 8'd0;
  logic       in_last_in = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out0;
  logic [7:0] out_out1;
  logic [7:0] out_out2;
  logic [7:0] out_out3;
  logic       out_last_out;

  pixel_tone_filter_unit dut (.*);

  always #5 clk = ~clk;

  pixel_t pixel_q[$];
  tone_t  tone_q[$];
  int     errors = 0;
  int     send_idle = 0;
  int     recv_stall = 0;
  int     hold_off = 0;
  logic [1:0] tone_mode = MODE_COLOUR;
  logic [1:0] boost_lvl = 2'd0;
  logic       alpha_on = 1'b1;
  logic [7:0] gamma_full [256];
  logic [7:0] gamma_tint [256];
  longint unsigned sep_k [3][3];
  longint unsigned gain_k [2];
  longint unsigned tgain_k [2];
  longint unsigned ofs_k [2];

  function automatic longint unsigned fx_const(longint unsigned n, longint unsigned d);
    return ((n << FB) + d / 2) / d;
  endfunction

  function automatic logic [7:0] gamma_entry(int p, longint unsigned k1, longint unsigned k2,
                                             int lim);
    longint unsigned rhs;
    longint unsigned t;
    int v;
    rhs = k2;
    for (int j = 0; j < 6; j++) rhs = rhs * longint'(p);
    v = 0;
    while (v < lim) begin
      t = 2 * longint'(v + 1) - 1;
      if (t * t * t * t * t * k1 > rhs) break;
      v++;
    end
    return 8'(v);
  endfunction

  function automatic logic [7:0] sat_index(longint unsigned a);
    longint unsigned i;
    i = a >> FB;
    return i > 255 ? 8'd255 : 8'(i);
  endfunction

  function automatic logic [7:0] scale_sat(longint unsigned a, longint unsigned g,
                                           longint unsigned o);
    longint unsigned v;
    v = (((a * g) >> FB) + o) >> FB;
    return v > 255 ? 8'd255 : 8'(v);
  endfunction

  function automatic tone_t predict_tone(pixel_t p);
    tone_t r;
    int b;
    int k;
    longint unsigned c [3];
    longint unsigned acc [3];
    longint unsigned s;
    logic [7:0] m;
    b = boost_lvl >= 2 ? 2 : int'(boost_lvl);
    k = b ? b - 1 : 0;
    c[0] = p.c0;
    c[1] = p.c1;
    c[2] = p.c2;
    for (int i = 0; i < 3; i++)
      acc[i] = sep_k[i][0] * c[0] + sep_k[i][1] * c[1] + sep_k[i][2] * c[2];
    case (tone_mode)
      MODE_COLOUR: begin
        if (b == 0) begin
          r.o0 = p.c2; r.o1 = p.c1; r.o2 = p.c0;
        end else begin
          r.o0 = scale_sat(c[2] << FB, gain_k[k], ofs_k[k]);
          r.o1 = scale_sat(c[1] << FB, gain_k[k], ofs_k[k]);
          r.o2 = scale_sat(c[0] << FB, gain_k[k], ofs_k[k]);
        end
      end
      MODE_MONO: begin
        s = 2 * c[0] + 3 * c[1] + c[2];
        m = b == 0 ? gamma_full[s / 6] : scale_sat((s << FB) / 6, gain_k[k], ofs_k[k]);
        r.o0 = m; r.o1 = m; r.o2 = m;
      end
      MODE_SEPIA: begin
        if (b == 0) begin
          r.o0 = gamma_full[sat_index(acc[2])];
          r.o1 = gamma_full[sat_index(acc[1])];
          r.o2 = gamma_full[sat_index(acc[0])];
        end else begin
          r.o0 = scale_sat(acc[2], gain_k[k], ofs_k[k]);
          r.o1 = scale_sat(acc[1], gain_k[k], ofs_k[k]);
          r.o2 = scale_sat(acc[0], gain_k[k], ofs_k[k]);
        end
      end
      default: begin
        if (b == 0) begin
          r.o0 = gamma_tint[sat_index(acc[2])];
          r.o1 = gamma_full[sat_index(acc[0])];
          r.o2 = gamma_tint[sat_index(acc[1])];
        end else begin
          r.o0 = scale_sat(acc[2], tgain_k[k], ofs_k[k]);
          r.o1 = scale_sat(acc[0], gain_k[k], ofs_k[k]);
          r.o2 = scale_sat(acc[1], tgain_k[k], ofs_k[k]);
        end
      end
    endcase
    r.o3 = alpha_on ? p.alpha : 8'd0;
    r.last = p.last;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      tone_q.push_back(predict_tone(pixel_q.pop_front()));
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() > (in_valid && in_ready ? 0 : 0) &&
          !(in_valid && in_ready && pixel_q.size() == 0) &&
          $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        {in_chan0, in_chan1, in_chan2, in_alpha_in, in_last_in} <= pixel_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tone_t got;
    tone_t want;
    if (out_valid && out_ready) begin
      got = {out_out0, out_out1, out_out2, out_out3, out_last_out};
      if (tone_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h", $time, got);
        errors++;
      end else begin
        want = tone_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected o0=%h o1=%h o2=%h o3=%h last=%b", $time,
                   want.o0, want.o1, want.o2, want.o3, want.last);
          $display("%0t:           actual   o0=%h o1=%h o2=%h o3=%h last=%b", $time,
                   got.o0, got.o1, got.o2, got.o3, got.last);
          errors++;
        end
      end
    end
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off > 0) out_ready <= 1'b0;
    else out_ready <= $urandom_range(99) >= recv_stall;
  end

  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TONE:  tone_mode = val;
      REG_BOOST: boost_lvl = val;
      REG_ALPHA: alpha_on = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || tone_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    pixel_q.push_back({a, b, c, 8'($urandom), 1'($urandom)});
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0: queue_pixel($urandom_range(1) ? 8'd255 : 8'd0, 8'($urandom),
                       $urandom_range(1) ? 8'd255 : 8'd0);
        default: queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      gamma_full[i] = gamma_entry(i, 255, 32, 255);
      gamma_tint[i] = gamma_entry(i, 796875, 7776, 153);
    end
    sep_k[0][0] = fx_const(393 * 85, 100000);
    sep_k[0][1] = fx_const(769 * 85, 100000);
    sep_k[0][2] = fx_const(189 * 85, 100000);
    sep_k[1][0] = fx_const(349 * 85, 100000);
    sep_k[1][1] = fx_const(686 * 85, 100000);
    sep_k[1][2] = fx_const(168 * 85, 100000);
    sep_k[2][0] = fx_const(272 * 85, 100000);
    sep_k[2][1] = fx_const(534 * 85, 100000);
    sep_k[2][2] = fx_const(131 * 85, 100000);
    gain_k[0] = fx_const(150, 100);
    gain_k[1] = fx_const(225, 100);
    tgain_k[0] = fx_const(90, 100);
    tgain_k[1] = fx_const(135, 100);
    ofs_k[0] = fx_const(2600, 100);
    ofs_k[1] = fx_const(6425, 100);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, then extremes in every mode
    pixel_q.push_back({8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
    pixel_q.push_back({8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
    pixel_q.push_back({8'd255, 8'd0, 8'd170, 8'h55, 1'b0});
    drain();
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_TONE, 2'(m));
      for (int b = 0; b < 4; b++) begin
        write_reg(REG_BOOST, 2'(b));
        write_reg(REG_ALPHA, 2'(b[0]));
        pixel_q.push_back({8'd255, 8'd255, 8'd255, 8'hAA, 1'b1});
        pixel_q.push_back({8'd0, 8'd0, 8'd0, 8'h55, 1'b0});
        drain();
      end
    end
    write_reg(2'd3, 2'd3);

    // random phases across settings and idling patterns
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 55; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 55; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      write_reg(REG_TONE, 2'($urandom));
      write_reg(REG_BOOST, 2'($urandom));
      write_reg(REG_ALPHA, 2'($urandom));
      if (ph == 4) hold_off = 60;
      queue_random(64);
      drain();
    end
    if (errors == 0 && tone_q.size() == 0) $display("** pixel_tone_filter_unit: PASSED **");
    else $display("** pixel_tone_filter_unit: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** pixel_tone_filter_unit: FAILED **");
    $finish;
  end

endmodule
